[rtl/bpk_pkg.sv]
package bpk_pkg;

  localparam int BYTE_W      = 8;
  localparam int FWIDTH_W    = 4;
  localparam logic [FWIDTH_W-1:0] FREE_RESET = 4'd8;
  localparam logic [FWIDTH_W-1:0] FIELD_MAX  = 4'd8;
  localparam logic [BYTE_W-1:0]   BYTE_ONES  = 8'hFF;

  // bytes one item leaves behind, ahead of the output register
  typedef struct packed {
    logic [BYTE_W-1:0] byte0;  // first byte of the burst
    logic [BYTE_W-1:0] byte1;  // flushed partial byte when a full byte came first
    logic              reach;  // the burst ends the instruction's byte count
  } emit_desc_t;

endpackage

[rtl/bpk_field_merge.sv]
module bpk_field_merge #(
  parameter int MAX_INSTR_BYTES = 8
) (
  input  logic [bpk_pkg::BYTE_W-1:0]     partial_byte,
  input  logic [bpk_pkg::FWIDTH_W-1:0]   free_bits,
  input  logic [$clog2(MAX_INSTR_BYTES+1)-1:0] bytes_emitted,
  input  logic [7:0]                     field_value,
  input  logic [3:0]                     field_width,
  input  logic [3:0]                     instruction_bytes,
  input  logic                           last_field,
  output logic [bpk_pkg::BYTE_W-1:0]     partial_byte_next,
  output logic [bpk_pkg::FWIDTH_W-1:0]   free_bits_next,
  output logic [$clog2(MAX_INSTR_BYTES+1)-1:0] bytes_emitted_next,
  output logic [$clog2(MAX_INSTR_BYTES+1)-1:0] emit_count,
  output bpk_pkg::emit_desc_t            desc
);

  localparam int CW = $clog2(MAX_INSTR_BYTES + 1);
  localparam int LW = (CW > 4) ? CW : 4;

  logic [LW-1:0]                   ib_ext;
  logic [LW-1:0]                   lim_ext;
  logic [CW-1:0]                   lim;
  logic [bpk_pkg::FWIDTH_W-1:0]    w;
  logic [bpk_pkg::BYTE_W-1:0]      bits;
  logic [bpk_pkg::FWIDTH_W-1:0]    rest;
  logic [bpk_pkg::BYTE_W-1:0]      full;
  logic                            has_full;
  logic [bpk_pkg::BYTE_W-1:0]      part_m;
  logic [bpk_pkg::FWIDTH_W-1:0]    free_m;
  logic [CW-1:0]                   em_m;
  logic [CW-1:0]                   em_fin;
  logic [CW-1:0]                   flush_cnt;

  // clamp the byte count to 1..MAX_INSTR_BYTES and the width to 0..8
  assign ib_ext  = LW'(instruction_bytes);
  assign lim_ext = (ib_ext == '0) ? LW'(1) :
                   (ib_ext > LW'(MAX_INSTR_BYTES)) ? LW'(MAX_INSTR_BYTES) : ib_ext;
  assign lim     = lim_ext[CW-1:0];
  assign w       = (field_width > bpk_pkg::FIELD_MAX) ? bpk_pkg::FIELD_MAX : field_width;
  assign bits    = (w == '0) ? '0 :
                   (field_value & (bpk_pkg::BYTE_ONES >> (bpk_pkg::FREE_RESET - w)));

  always_comb begin
    rest      = '0;
    full      = '0;
    has_full  = 1'b0;
    part_m    = partial_byte;
    free_m    = free_bits;
    em_m      = bytes_emitted;
    if (w != '0 && bytes_emitted < lim) begin
      if (w < free_bits) begin
        part_m = partial_byte | (bits << (free_bits - w));
        free_m = free_bits - w;
      end else begin
        rest     = w - free_bits;
        full     = partial_byte | (bits >> rest);
        has_full = 1'b1;
        em_m     = bytes_emitted + CW'(1);
        part_m   = '0;
        free_m   = bpk_pkg::FREE_RESET;
        if (rest != '0 && em_m < lim) begin
          part_m = bits << (bpk_pkg::FREE_RESET - rest);
          free_m = bpk_pkg::FREE_RESET - rest;
        end
      end
    end
  end

  // flush the partial byte and pad with zeros up to the count
  always_comb begin
    flush_cnt          = '0;
    em_fin             = em_m;
    partial_byte_next  = part_m;
    free_bits_next     = free_m;
    bytes_emitted_next = em_m;
    if (last_field) begin
      if (em_m < lim) begin
        flush_cnt = lim - em_m;
        em_fin    = lim;
      end
      partial_byte_next  = '0;
      free_bits_next     = bpk_pkg::FREE_RESET;
      bytes_emitted_next = '0;
    end
  end

  assign emit_count  = flush_cnt + CW'(has_full);
  assign desc.byte0  = has_full ? full : part_m;
  assign desc.byte1  = has_full ? part_m : '0;
  assign desc.reach  = (em_fin >= lim);

endmodule

[rtl/variable_width_bit_packer_core.sv]
// msb-first bit field packer
//
// input channel: in_valid / in_ready with field_value, field_width,
// instruction_bytes and last_field. each item is a field of 0 to 8 bits
// that is merged into a partial byte, most significant bit first
// output channel: out_valid / out_ready with out_byte and last_byte, zero
// or more packed bytes per item; last_byte marks the byte that completes the
// instruction's byte count
// config channel: cfg_valid / cfg_ready with emit_enable, always ready;
// with emit_enable low fields still pack into the state but no bytes leave
// a byte caused by an item is on the output the cycle after the item is
// taken. one item per cycle while the receiver is ready and each item causes
// at most one byte; an item that ends an instruction holds the output
// register with each byte it causes in turn (flush plus zero padding, up
// to MAX_INSTR_BYTES), and the next item waits for that burst to drain.
// in_ready depends on out_ready only when the last byte of a burst leaves
// reset: empty partial byte, eight free bits, no bytes emitted, emit_enable
// high, output register empty
// a stalled receiver holds the current byte; the next item is taken in the
// same cycle that the last pending byte is taken
module variable_width_bit_packer_core #(
  parameter int MAX_INSTR_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] field_value,
  input  logic [3:0] field_width,
  input  logic [3:0] instruction_bytes,
  input  logic       last_field,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       emit_enable
);

  localparam int CW = $clog2(MAX_INSTR_BYTES + 1);

  // packing state
  logic                         enable;
  logic [bpk_pkg::BYTE_W-1:0]   partial_byte;
  logic [bpk_pkg::FWIDTH_W-1:0] free_bits;
  logic [CW-1:0]                bytes_emitted;

  logic [bpk_pkg::BYTE_W-1:0]   partial_byte_next;
  logic [bpk_pkg::FWIDTH_W-1:0] free_bits_next;
  logic [CW-1:0]                bytes_emitted_next;
  logic [CW-1:0]                emit_count;
  bpk_pkg::emit_desc_t          desc;

  // output register: the burst still to be delivered
  logic [bpk_pkg::BYTE_W-1:0]   byte0;
  logic [bpk_pkg::BYTE_W-1:0]   byte1;
  logic [CW-1:0]                remain;
  logic                         reach;

  logic in_fire;
  logic out_fire;

  bpk_field_merge #(
    .MAX_INSTR_BYTES(MAX_INSTR_BYTES)
  ) u_merge (
    .partial_byte       (partial_byte),
    .free_bits          (free_bits),
    .bytes_emitted      (bytes_emitted),
    .field_value        (field_value),
    .field_width        (field_width),
    .instruction_bytes  (instruction_bytes),
    .last_field         (last_field),
    .partial_byte_next  (partial_byte_next),
    .free_bits_next     (free_bits_next),
    .bytes_emitted_next (bytes_emitted_next),
    .emit_count         (emit_count),
    .desc               (desc)
  );

  // free when empty, or when the final pending byte leaves this cycle
  assign in_ready  = (remain == '0) || (remain == CW'(1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (remain != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_byte  = byte0;
  assign last_byte = reach && (remain == CW'(1));
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_valid) begin
      enable <= emit_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte  <= '0;
      free_bits     <= bpk_pkg::FREE_RESET;
      bytes_emitted <= '0;
    end else if (in_fire) begin
      partial_byte  <= partial_byte_next;
      free_bits     <= free_bits_next;
      bytes_emitted <= bytes_emitted_next;
    end
  end

  // remaining count is control; the byte slots are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (in_fire) begin
      remain <= enable ? emit_count : '0;
    end else if (out_fire) begin
      remain <= remain - CW'(1);
    end
  end

  // after the first two bytes of a burst only zero padding follows
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte0 <= desc.byte0;
      byte1 <= desc.byte1;
      reach <= desc.reach;
    end else if (out_fire) begin
      byte0 <= byte1;
      byte1 <= '0;
    end
  end

endmodule
